FILE: rtl/dqp_pkg.sv
// ----------------------------------------------------------------------------
// dqp_pkg
// Shared types and codes for the DNS question parser.
// ----------------------------------------------------------------------------
package dqp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_packet;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  name_byte;
		logic [15:0] query_type;
		logic [15:0] query_class;
		logic [7:0]  name_length;
		logic [1:0]  error_code;
	} out_word_t;

	localparam logic [1:0] KIND_NAME     = 2'd0;
	localparam logic [1:0] KIND_COMPLETE = 2'd1;
	localparam logic [1:0] KIND_REJECT   = 2'd2;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_LABEL_TYP = 2'd1;
	localparam logic [1:0] ERR_TOO_LONG  = 2'd2;
	localparam logic [1:0] ERR_TRUNCATED = 2'd3;

	localparam logic [7:0] LABEL_TYPE_MASK = 8'hc0;
	localparam logic [7:0] MAX_NAME_LEN_RST = 8'd255;

endpackage

FILE: rtl/dns_question_parser_top.sv
// ----------------------------------------------------------------------------
// dns_question_parser_top
// DNS question section parser: echoes name bytes, returns type and class or an error code.
//
//   channel  direction  handshake                  word
//   byte     in         byte_valid / byte_stall    data_byte, end_of_packet
//   result   out        result_valid / result_stall kind .. error_code
//   cfg      in         cfg_wr_en                  max_name_len
//
// One word per cycle unless byte_stall is high; with the buffer empty a result
// reaches result_word the cycle after its byte, otherwise it waits behind the older word.
// Results queue in a two-entry buffer; byte_stall rises only when it is full.
// Reset clears the parser state and sets max_name_len to 255.
// ----------------------------------------------------------------------------
module dns_question_parser_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  dqp_pkg::in_word_t  byte_word,
	output logic               result_valid,
	input  logic               result_stall,
	output dqp_pkg::out_word_t result_word,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_wr_data
);
	import dqp_pkg::*;

	logic      accept;
	logic      res_valid;
	out_word_t res_word;
	logic      buf_full;
	logic [7:0] max_name_len_q;

	assign byte_stall = buf_full;
	assign accept     = byte_valid && !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_name_len_q <= MAX_NAME_LEN_RST;
		end else if (cfg_wr_en) begin
			max_name_len_q <= cfg_wr_data;
		end
	end

	dqp_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_word      (byte_word),
		.max_name_len (max_name_len_q),
		.res_valid    (res_valid),
		.res_word     (res_word)
	);

	dqp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && res_valid),
		.push_word (res_word),
		.full      (buf_full),
		.valid     (result_valid),
		.stall     (result_stall),
		.word      (result_word)
	);

`ifndef SYNTHESIS
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> result_valid)
		else $error("byte_stall with empty result buffer");

	a_name_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_word.kind == KIND_NAME) |->
		(result_word.error_code == ERR_NONE && result_word.name_length == 8'd0))
		else $error("name word carries stray fields");

	a_reject_code: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_word.kind == KIND_REJECT) |->
		(result_word.error_code != ERR_NONE))
		else $error("rejection without error code");

	a_complete_len: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_word.kind == KIND_COMPLETE) |->
		(result_word.name_length != 8'd0 && result_word.error_code == ERR_NONE))
		else $error("completion with bad length or error");
`endif

endmodule

FILE: rtl/dqp_parse.sv
// ----------------------------------------------------------------------------
// dqp_parse
// Label walker: per-word state update and result generation.
// ----------------------------------------------------------------------------
module dqp_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  dqp_pkg::in_word_t in_word,
	input  logic [7:0]        max_name_len,
	output logic              res_valid,
	output dqp_pkg::out_word_t res_word
);
	import dqp_pkg::*;

	localparam logic [1:0] PH_LEN   = 2'd0;
	localparam logic [1:0] PH_LABEL = 2'd1;
	localparam logic [1:0] PH_TAIL  = 2'd2;
	localparam logic [1:0] PH_SKIP  = 2'd3;

	logic [1:0]  phase_q, phase_n;
	logic [5:0]  label_left_q, label_left_n;
	logic [7:0]  name_offset_q, name_offset_n;
	logic [1:0]  tail_count_q, tail_count_n;
	logic [23:0] type_class_q, type_class_n;

	logic [7:0]  b;
	logic        eop;
	logic [31:0] tc_full;
	logic        rej;
	logic [1:0]  rej_code;
	logic        clr;

	assign b       = in_word.data_byte;
	assign eop     = in_word.end_of_packet;
	assign tc_full = {type_class_q, b};

	always_comb begin
		phase_n       = phase_q;
		label_left_n  = label_left_q;
		name_offset_n = name_offset_q;
		tail_count_n  = tail_count_q;
		type_class_n  = type_class_q;
		res_valid     = 1'b0;
		res_word      = '0;
		rej           = 1'b0;
		rej_code      = ERR_NONE;
		clr           = 1'b0;
		unique case (phase_q)
			PH_LEN: begin
				if (b == 8'd0) begin
					if (({1'b0, name_offset_q} + 9'd1) > {1'b0, max_name_len}) begin
						rej      = 1'b1;
						rej_code = ERR_TOO_LONG;
					end else if (eop) begin
						rej      = 1'b1;
						rej_code = ERR_TRUNCATED;
					end else begin
						res_valid          = 1'b1;
						res_word.kind      = KIND_NAME;
						name_offset_n      = name_offset_q + 8'd1;
						phase_n            = PH_TAIL;
						tail_count_n       = 2'd0;
						type_class_n       = '0;
					end
				end else if ((b & LABEL_TYPE_MASK) != 8'd0) begin
					rej      = 1'b1;
					rej_code = ERR_LABEL_TYP;
				end else if (eop) begin
					rej      = 1'b1;
					rej_code = ERR_TRUNCATED;
				end else if (({2'b0, name_offset_q} + {2'b0, b} + 10'd2) >
						{2'b0, max_name_len}) begin
					rej      = 1'b1;
					rej_code = ERR_TOO_LONG;
				end else begin
					res_valid          = 1'b1;
					res_word.kind      = KIND_NAME;
					res_word.name_byte = b;
					name_offset_n      = name_offset_q + 8'd1;
					label_left_n       = b[5:0];
					phase_n            = PH_LABEL;
				end
			end
			PH_LABEL: begin
				if (eop) begin
					rej      = 1'b1;
					rej_code = ERR_TRUNCATED;
				end else begin
					res_valid          = 1'b1;
					res_word.kind      = KIND_NAME;
					res_word.name_byte = b;
					name_offset_n      = name_offset_q + 8'd1;
					label_left_n       = label_left_q - 6'd1;
					if (label_left_q == 6'd1) begin
						phase_n = PH_LEN;
					end
				end
			end
			PH_TAIL: begin
				if (tail_count_q == 2'd3) begin
					res_valid            = 1'b1;
					res_word.kind        = KIND_COMPLETE;
					res_word.query_type  = tc_full[31:16];
					res_word.query_class = tc_full[15:0];
					res_word.name_length = name_offset_q;
					clr                  = 1'b1;
				end else if (eop) begin
					rej      = 1'b1;
					rej_code = ERR_TRUNCATED;
				end else begin
					tail_count_n = tail_count_q + 2'd1;
					type_class_n = tc_full[23:0];
				end
			end
			PH_SKIP: begin
				if (eop) begin
					clr = 1'b1;
				end
			end
			default: begin
				phase_n = PH_LEN;
			end
		endcase
		if (rej) begin
			res_valid           = 1'b1;
			res_word            = '0;
			res_word.kind       = KIND_REJECT;
			res_word.error_code = rej_code;
			clr                 = 1'b1;
		end
		if (clr) begin
			phase_n       = eop ? PH_LEN : PH_SKIP;
			label_left_n  = '0;
			name_offset_n = '0;
			tail_count_n  = '0;
			type_class_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_LEN;
			label_left_q  <= '0;
			name_offset_q <= '0;
			tail_count_q  <= '0;
			type_class_q  <= '0;
		end else if (accept) begin
			phase_q       <= phase_n;
			label_left_q  <= label_left_n;
			name_offset_q <= name_offset_n;
			tail_count_q  <= tail_count_n;
			type_class_q  <= type_class_n;
		end
	end

endmodule

FILE: rtl/dqp_out_buf.sv
// ----------------------------------------------------------------------------
// dqp_out_buf
// Two-entry result buffer; decouples upstream from the result stall.
// ----------------------------------------------------------------------------
module dqp_out_buf (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dqp_pkg::out_word_t push_word,
	output logic               full,
	output logic               valid,
	input  logic               stall,
	output dqp_pkg::out_word_t word
);
	import dqp_pkg::*;

	out_word_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       pop;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign pop   = valid && !stall;
	assign word  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: bench/dns_question_parser_top_test.sv
// ----------------------------------------------------------------------------
// dns_question_parser_top_test
// Self-checking bench for the DNS question parser. Packet bytes are sent as
// directed and random questions under random idling and back-pressure. An
// in-bench parser predicts every result word, and each word taken from the
// block is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dns_question_parser_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dqp_pkg::*;

	typedef enum logic [1:0] {AT_LEN, IN_LABEL, AT_TAIL, SKIPPING} parse_phase_t;

	logic      clk;
	logic      arst_n;
	logic      byte_valid;
	logic      byte_stall;
	in_word_t  byte_word;
	logic      result_valid;
	logic      result_stall;
	out_word_t result_word;
	logic      cfg_wr_en;
	logic [7:0] cfg_wr_data;

	// parser state as the bench sees it
	parse_phase_t phase;
	logic [5:0]   label_left;
	logic [7:0]   name_offset;
	logic [1:0]   tail_count;
	logic [31:0]  type_class;
	logic [7:0]   max_len;

	out_word_t predicted_results[$];
	int        error_count = 0;
	int        bytes_accepted = 0;
	int        send_gap_max = 0;
	int        recv_gap_max = 0;
	int        hold_cycles = 0;

	dns_question_parser_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_word    (byte_word),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_word  (result_word),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#10ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic int draw_gap(input int hi);
		return $urandom_range(0, hi);
	endfunction

	function automatic void clear_question();
		phase = AT_LEN;
		label_left = '0;
		name_offset = '0;
		tail_count = '0;
		type_class = '0;
	endfunction

	function automatic out_word_t reject_question(input logic [1:0] code, input logic eop);
		out_word_t r;
		r = '0;
		r.kind = KIND_REJECT;
		r.error_code = code;
		clear_question();
		if (!eop)
			phase = SKIPPING;
		return r;
	endfunction

	// returns 1 when the byte yields a result word
	function automatic bit parse_byte(input logic [7:0] b, input logic eop,
			output out_word_t r);
		r = '0;
		case (phase)
			AT_LEN: begin
				if (b == 8'd0) begin
					if ({1'b0, name_offset} + 9'd1 > {1'b0, max_len})
						r = reject_question(ERR_TOO_LONG, eop);
					else if (eop)
						r = reject_question(ERR_TRUNCATED, eop);
					else begin
						r.kind = KIND_NAME;
						name_offset = name_offset + 8'd1;
						phase = AT_TAIL;
						tail_count = '0;
						type_class = '0;
					end
				end else if ((b & LABEL_TYPE_MASK) != 8'd0)
					r = reject_question(ERR_LABEL_TYP, eop);
				else if (eop)
					r = reject_question(ERR_TRUNCATED, eop);
				else if ({2'b00, name_offset} + {2'b00, b} + 10'd2 > {2'b00, max_len})
					r = reject_question(ERR_TOO_LONG, eop);
				else begin
					r.kind = KIND_NAME;
					r.name_byte = b;
					name_offset = name_offset + 8'd1;
					label_left = b[5:0];
					phase = IN_LABEL;
				end
				return 1'b1;
			end
			IN_LABEL: begin
				if (eop)
					r = reject_question(ERR_TRUNCATED, eop);
				else begin
					r.kind = KIND_NAME;
					r.name_byte = b;
					name_offset = name_offset + 8'd1;
					label_left = label_left - 6'd1;
					if (label_left == 6'd0)
						phase = AT_LEN;
				end
				return 1'b1;
			end
			AT_TAIL: begin
				type_class = {type_class[23:0], b};
				if (tail_count == 2'd3) begin
					r.kind = KIND_COMPLETE;
					r.query_type = type_class[31:16];
					r.query_class = type_class[15:0];
					r.name_length = name_offset;
					clear_question();
					if (!eop)
						phase = SKIPPING;
					return 1'b1;
				end
				if (eop) begin
					r = reject_question(ERR_TRUNCATED, eop);
					return 1'b1;
				end
				tail_count = tail_count + 2'd1;
				return 1'b0;
			end
			default: begin
				if (eop)
					clear_question();
				return 1'b0;
			end
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] data, input logic eop);
		int gap;
		out_word_t r;
		gap = draw_gap(send_gap_max);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_word <= {data, eop};
		do @(posedge clk); while (byte_stall);
		if (parse_byte(data, eop, r))
			predicted_results.push_back(r);
		bytes_accepted++;
	endtask

	// bytes are taken from the most significant end; the last one ends the packet
	task automatic send_packet(input logic [127:0] bytes, input int count);
		for (int i = 0; i < count; i++)
			send_byte(bytes[8 * (count - 1 - i) +: 8], i == count - 1);
	endtask

	task automatic settle();
		byte_valid <= 1'b0;
		while (predicted_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_len(input logic [7:0] value);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		max_len = value;
	endtask

	task automatic send_random_packet();
		logic [7:0] bytes[$];
		int labels;
		int len;
		int style;
		int cut;
		style = $urandom_range(0, 9);
		if (style == 0) begin
			repeat ($urandom_range(1, 12)) bytes.push_back(8'($urandom));
		end else begin
			labels = $urandom_range(0, 4);
			repeat (labels) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 8);
				bytes.push_back(8'(len));
				repeat (len) bytes.push_back(8'($urandom));
			end
			bytes.push_back(8'h00);
			repeat (4) bytes.push_back(8'($urandom));
			repeat ($urandom_range(0, 3)) bytes.push_back(8'($urandom));
			if (style == 1) begin
				cut = $urandom_range(1, bytes.size());
				while (bytes.size() > cut)
					void'(bytes.pop_back());
			end else if (style == 2) begin
				bytes[0] = {2'($urandom_range(1, 3)), 6'($urandom)};
			end
		end
		foreach (bytes[i])
			send_byte(bytes[i], i == bytes.size() - 1);
	endtask

	task automatic test_complete_questions();
		send_gap_max = 0;
		recv_gap_max = 0;
		send_packet(40'h00_12_34_ab_cd, 5);
		send_packet(64'h01_ff_00_00_01_00_01_5a, 8);
		send_packet(80'h02_00_80_00_ff_ff_00_00_11_22, 10);
	endtask

	task automatic test_rejections();
		send_gap_max = 18;
		recv_gap_max = 18;
		send_packet(8'hc0, 1);
		send_packet(24'h40_33_44, 3);
		send_packet(16'h80_00, 2);
		send_packet(8'h3f, 1);
		send_packet(16'h01_00, 2);
		send_packet(8'h00, 1);
		send_packet(24'h00_01_02, 3);
		send_packet(32'h00_01_02_03, 4);
	endtask

	task automatic test_length_limit();
		write_max_len(8'd2);
		send_packet(40'h00_01_02_03_04, 5);
		send_packet(24'h01_61_00, 3);
		write_max_len(8'd3);
		send_packet(56'h01_61_00_00_1c_00_01, 7);
		write_max_len(8'd0);
		send_packet(8'h00, 1);
		write_max_len(8'd255);
	endtask

	task automatic test_backpressure();
		settle();
		send_gap_max = 0;
		hold_cycles = 60;
		repeat (3) begin
			send_byte(8'h3f, 1'b0);
			repeat (63) send_byte(8'($urandom), 1'b0);
			send_byte(8'h00, 1'b0);
			repeat (3) send_byte(8'($urandom), 1'b0);
			send_byte(8'($urandom), 1'b1);
		end
	endtask

	task automatic test_random_traffic();
		int stop_at;
		stop_at = bytes_accepted + 1300;
		for (int ph = 0; bytes_accepted < stop_at; ph++) begin
			case (ph % 4)
				0: write_max_len(8'd255);
				1: write_max_len(8'($urandom_range(2, 40)));
				2: write_max_len(8'd2);
				default: write_max_len(8'($urandom_range(0, 255)));
			endcase
			send_gap_max = (ph % 3 == 0) ? 0 : 18;
			recv_gap_max = (ph % 5 == 0) ? 0 : 18;
			repeat (10) send_random_packet();
		end
	endtask

	initial begin : result_sink
		int n;
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
			end else
				n = draw_gap(recv_gap_max);
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	always @(posedge clk) begin : result_check
		out_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (predicted_results.size() == 0) begin
				$error("unexpected result word %h", result_word);
				error_count++;
			end else begin
				want = predicted_results.pop_front();
				if (result_word.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, result_word.kind);
					error_count++;
				end
				if (result_word.name_byte !== want.name_byte) begin
					$error("name_byte: expected %0h, got %0h", want.name_byte,
						result_word.name_byte);
					error_count++;
				end
				if (result_word.query_type !== want.query_type) begin
					$error("query_type: expected %0h, got %0h", want.query_type,
						result_word.query_type);
					error_count++;
				end
				if (result_word.query_class !== want.query_class) begin
					$error("query_class: expected %0h, got %0h", want.query_class,
						result_word.query_class);
					error_count++;
				end
				if (result_word.name_length !== want.name_length) begin
					$error("name_length: expected %0d, got %0d", want.name_length,
						result_word.name_length);
					error_count++;
				end
				if (result_word.error_code !== want.error_code) begin
					$error("error_code: expected %0d, got %0d", want.error_code,
						result_word.error_code);
					error_count++;
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		byte_valid <= 1'b0;
		byte_word <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		max_len = MAX_NAME_LEN_RST;
		clear_question();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_complete_questions();
		test_rejections();
		test_length_limit();
		test_backpressure();
		test_random_traffic();

		byte_valid <= 1'b0;
		for (int k = 0; k < 2000 && predicted_results.size() != 0; k++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (predicted_results.size() != 0) begin
			$error("%0d result words never arrived", predicted_results.size());
			error_count++;
		end
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: sim.f
rtl/dqp_pkg.sv
rtl/dqp_parse.sv
rtl/dqp_out_buf.sv
rtl/dns_question_parser_top.sv
bench/dns_question_parser_top_test.sv
